### hw/rtl/vn_pkg.sv
// ----------------------------------------------------------------------------
// Vector normalizer package
// Widths, stage payload types and constants shared by the normalizer cells.
// ----------------------------------------------------------------------------
package vn_pkg;

	localparam int CW       = 16;
	localparam int FB       = 14;
	localparam int NW       = 2 * CW + 2 * FB + 2;
	localparam int RW       = NW / 2;
	localparam int QW       = FB + 1;
	localparam int OW       = FB + 2;
	localparam int PW       = 2 * CW;
	localparam int SW       = 2 * CW + 2;
	localparam int RT_STEPS = NW / 2;
	localparam int SQ_IW    = $clog2(RT_STEPS);
	localparam int SH_W     = $clog2(NW);
	localparam int DV_IW    = $clog2(QW);

	typedef struct packed {
		logic [2:0][CW-1:0] mag;
		logic [2:0]         neg;
		logic               td;
		logic               zero;
		logic [NW-1:0]      n;
		logic [NW-1:0]      root;
	} sq_t;

	typedef struct packed {
		logic [2:0]         neg;
		logic               td;
		logic               zero;
		logic [RW-1:0]      r;
		logic [2:0][NW-1:0] rem;
		logic [2:0][QW-1:0] q;
	} dv_t;

endpackage

### hw/rtl/vn_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One bit pair of the digit-by-digit integer square root, registered.
// ----------------------------------------------------------------------------
module vn_sqrt_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [vn_pkg::SQ_IW-1:0] idx,
	input  logic                   vld_in,
	input  vn_pkg::sq_t            din,
	output logic                   vld_q,
	output vn_pkg::sq_t            dout_q
);
	import vn_pkg::*;

	logic [SH_W-1:0] sh;
	logic [NW-1:0]   bitv;
	logic [NW:0]     trial;
	sq_t             nxt;

	always_comb begin
		sh    = SH_W'(NW - 2) - SH_W'({idx, 1'b0});
		bitv  = NW'(1) << sh;
		trial = {1'b0, din.root} + {1'b0, bitv};
		nxt   = din;
		if ({1'b0, din.n} >= trial) begin
			nxt.n    = din.n - trial[NW-1:0];
			nxt.root = (din.root >> 1) + bitv;
		end else begin
			nxt.root = din.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout_q <= nxt;
		end
	end

endmodule

### hw/rtl/vn_div_cell.sv
// ----------------------------------------------------------------------------
// Divide cell
// One quotient bit of the restoring division for all three lanes, registered.
// ----------------------------------------------------------------------------
module vn_div_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [vn_pkg::DV_IW-1:0] idx,
	input  logic                   vld_in,
	input  vn_pkg::dv_t            din,
	output logic                   vld_q,
	output vn_pkg::dv_t            dout_q
);
	import vn_pkg::*;

	logic [DV_IW-1:0] qb;
	logic [NW-1:0]    dv;
	dv_t              nxt;

	always_comb begin
		qb  = DV_IW'(FB) - idx;
		dv  = NW'(din.r) << qb;
		nxt = din;
		for (int j = 0; j < 3; j++) begin
			if (din.rem[j] >= dv) begin
				nxt.rem[j]   = din.rem[j] - dv;
				nxt.q[j][qb] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout_q <= nxt;
		end
	end

endmodule

### hw/rtl/vector_normalizer.sv
// Throughput: one request per cycle; the whole pipeline holds only while a
// finished result waits on a low m_axis_tready. Depth is set by the input
// stages, the 31 square root cells, the 15 divide cells and the output
// register. Reset clears all valid flags and the mode register to
// two-dimensional.
// ----------------------------------------------------------------------------
// Vector normalizer
// Scales a 2D or 3D vector to unit length in Q1.14 through a chain of cells.
// ----------------------------------------------------------------------------
module vector_normalizer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic                      cfg_wr_data,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [3*vn_pkg::CW-1:0]   s_axis_tdata,   // vec_x, vec_y, vec_z
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [3*vn_pkg::CW-1:0]   m_axis_tdata,   // unit_x, unit_y, unit_z
	output logic                      m_axis_tuser    // zero_length
);
	import vn_pkg::*;

	logic                 td_q;
	logic                 en;
	logic                 v_s1, v_s2, v_s3;
	logic [2:0][CW-1:0]   mag_s1, mag_s2;
	logic [2:0]           neg_s1, neg_s2;
	logic                 td_s1, td_s2;
	logic [2:0][PW-1:0]   prod_s2;
	logic [2:0][CW-1:0]   mag_in;
	logic [2:0]           neg_in;
	logic [SW-1:0]        s_sum;
	sq_t                  sq_s3;
	sq_t                  sq_c [0:RT_STEPS];
	logic                 sv   [0:RT_STEPS];
	dv_t                  dv_c [0:QW];
	logic                 dvv  [0:QW];
	logic [2:0][OW-1:0]   unit;
	logic [2:0][QW-1:0]   qs;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			td_q <= 1'b0;
		end else if (cfg_wr_en) begin
			td_q <= cfg_wr_data;
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			neg_in[j] = s_axis_tdata[j*CW + CW - 1];
			mag_in[j] = neg_in[j] ? (~s_axis_tdata[j*CW +: CW]) + CW'(1)
				: s_axis_tdata[j*CW +: CW];
		end
		if (!td_q) begin
			neg_in[2] = 1'b0;
			mag_in[2] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign s_sum = SW'(prod_s2[0]) + SW'(prod_s2[1]) + SW'(prod_s2[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_in;
			neg_s1 <= neg_in;
			td_s1  <= td_q;
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			td_s2  <= td_s1;
			for (int j = 0; j < 3; j++) begin
				prod_s2[j] <= mag_s1[j] * mag_s1[j];
			end
			sq_s3.mag  <= mag_s2;
			sq_s3.neg  <= neg_s2;
			sq_s3.td   <= td_s2;
			sq_s3.zero <= (s_sum == '0);
			sq_s3.n    <= NW'(s_sum) << (2 * FB);
			sq_s3.root <= '0;
		end
	end

	assign sq_c[0] = sq_s3;
	assign sv[0]   = v_s3;

	for (genvar k = 0; k < RT_STEPS; k++) begin : g_sqrt
		vn_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.idx    (SQ_IW'(k)),
			.vld_in (sv[k]),
			.din    (sq_c[k]),
			.vld_q  (sv[k+1]),
			.dout_q (sq_c[k+1])
		);
	end

	always_comb begin
		dv_c[0].neg  = sq_c[RT_STEPS].neg;
		dv_c[0].td   = sq_c[RT_STEPS].td;
		dv_c[0].zero = sq_c[RT_STEPS].zero;
		dv_c[0].r    = sq_c[RT_STEPS].root[RW-1:0];
		for (int j = 0; j < 3; j++) begin
			dv_c[0].rem[j] = NW'(sq_c[RT_STEPS].mag[j]) << (2 * FB);
			dv_c[0].q[j]   = '0;
		end
	end
	assign dvv[0] = sv[RT_STEPS];

	for (genvar k = 0; k < QW; k++) begin : g_div
		vn_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.idx    (DV_IW'(k)),
			.vld_in (dvv[k]),
			.din    (dv_c[k]),
			.vld_q  (dvv[k+1]),
			.dout_q (dv_c[k+1])
		);
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			qs[j]   = (dv_c[QW].q[j] > (QW'(1) << FB)) ? (QW'(1) << FB) : dv_c[QW].q[j];
			unit[j] = dv_c[QW].neg[j] ? (~OW'(qs[j])) + OW'(1) : OW'(qs[j]);
			if (dv_c[QW].zero) begin
				unit[j] = '0;
			end
		end
		if (!dv_c[QW].td) begin
			unit[2] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= dvv[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {CW'(unit[2]), CW'(unit[1]), CW'(unit[0])};
			m_axis_tuser <= dv_c[QW].zero;
		end
	end

endmodule

### hw/rtl/vn_checker.sv
// ----------------------------------------------------------------------------
// Vector normalizer checker
// Port-level assertions for the normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module vn_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_axis_tready,
	input logic                    m_axis_tvalid,
	input logic                    m_axis_tready,
	input logic [3*vn_pkg::CW-1:0] m_axis_tdata,
	input logic                    m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with an empty output");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("zero-length result carries nonzero components");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= 16'sd16384
			&& $signed(m_axis_tdata[15:0]) >= -16'sd16384)
		else $error("unit x out of range");

endmodule

bind vector_normalizer vn_checker u_vn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Vector normalizer testbench
// Streams 2D and 3D vectors through the normalizer under both modes, with
// random idling on both sides and one long output hold-off, and compares
// every result with a behavioral Q1.14 normalization.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY   = 50;
	localparam int CYCLE_CAP = 400000;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic        zero;
	} unit_vec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;

	logic        mode_3d = 1'b0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_cycles = 0;
	int          errors = 0;
	int          cycles = 0;
	unit_vec_t   expected_units[$];

	vector_normalizer u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic [15:0] scale_component(input logic [15:0] c, input logic [63:0] r);
		logic [63:0] mag;
		logic [63:0] q;
		mag = c[15] ? 64'(17'h10000 - {1'b0, c}) : 64'(c);
		q = (mag << 28) / r;
		if (q > 64'd16384) q = 64'd16384;
		if (c[15]) q = -q;
		return q[15:0];
	endfunction

	function automatic unit_vec_t normalize(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z, input logic three_d);
		unit_vec_t u;
		logic [63:0] s;
		logic [63:0] r;
		logic [15:0] zz;
		zz = three_d ? z : 16'd0;
		s = 64'($signed(x) * $signed(x)) + 64'($signed(y) * $signed(y))
			+ 64'($signed(zz) * $signed(zz));
		u = '0;
		if (s == 0) begin
			u.zero = 1'b1;
			return u;
		end
		r = int_sqrt(s << 28);
		if (r == 0) r = 1;
		u.x = scale_component(x, r);
		u.y = scale_component(y, r);
		u.z = three_d ? scale_component(zz, r) : 16'd0;
		return u;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	task automatic send_vector(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {z, y, x};
		do @(posedge clk); while (!s_axis_tready);
		expected_units.push_back(normalize(x, y, z, mode_3d));
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		unit_vec_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_units.size() == 0) begin
				report("unexpected result", m_axis_tdata[31:0], 32'd0);
			end else begin
				want = expected_units.pop_front();
				if (m_axis_tdata[15:0] !== want.x)
					report("unit_x", 32'(m_axis_tdata[15:0]), 32'(want.x));
				if (m_axis_tdata[31:16] !== want.y)
					report("unit_y", 32'(m_axis_tdata[31:16]), 32'(want.y));
				if (m_axis_tdata[47:32] !== want.z)
					report("unit_z", 32'(m_axis_tdata[47:32]), 32'(want.z));
				if (m_axis_tuser !== want.zero)
					report("zero_length", 32'(m_axis_tuser), 32'(want.zero));
			end
		end
	end

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_units.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic set_mode(input logic three_d);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= three_d;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mode_3d = three_d;
	endtask

	function automatic logic [15:0] rand_component();
		case ($urandom_range(5))
			0: return 16'(16'h8000 + $urandom_range(3));
			1: return 16'(16'h7fff - $urandom_range(3));
			2: return 16'($signed($urandom_range(8)) - 4);
			3: return 16'($urandom_range(255));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		logic [15:0] ext[6];
		ext = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h5555};
		for (int i = 0; i < 6; i++) send_vector(ext[i], ext[(i + 1) % 6], ext[(i + 3) % 6]);
		send_vector(16'h0000, 16'h0000, 16'h0000);
		send_vector(16'h0000, 16'h0000, 16'h1234);
		send_vector(16'h8000, 16'h8000, 16'h8000);
		send_vector(16'h0000, 16'h0000, 16'h8000);
		send_vector(16'h0003, 16'hfffc, 16'h0000);
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) send_vector(rand_component(), rand_component(), rand_component());
	endtask

	task automatic test_backpressure();
		hold_cycles <= 200;
		for (int i = 0; i < 120; i++) send_vector(rand_component(), rand_component(), rand_component());
	endtask

	initial begin
		send_idle_pct = 27;
		recv_idle_pct = 53;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		set_mode(1'b1);
		test_directed();
		test_random(300);
		set_mode(1'b0);
		send_idle_pct = 53;
		recv_idle_pct = 27;
		test_random(300);
		set_mode(1'b1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(200);
		test_backpressure();
		set_mode(1'b0);
		test_random(100);
		drain();
		if (errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end
endmodule
